>>> src/rps_pkg.sv
// shared constants and types for the sphere point scaler
package rps_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int LEN_FRAC      = 16;
    localparam int DRAW_W        = 14;
    localparam int CTR_W         = DRAW_W + 1;
    localparam int SQ_W          = 2 * DRAW_W;
    localparam int SUM_W         = SQ_W + 1;
    localparam int PAD_W         = 2 * ((SUM_W + 1) / 2);
    localparam int ROOT_W        = PAD_W / 2 + LEN_FRAC;
    localparam int SQRT_STAGES   = ROOT_W;
    localparam int REM_W         = ROOT_W + 1;
    localparam int MAG_W         = DRAW_W;
    localparam int POS_W         = 32;
    localparam int RAD_W         = POS_W - 1;
    localparam int PROD_W        = MAG_W + RAD_W;
    localparam int Q_W           = POS_W - 1;
    localparam int NUM_W         = PROD_W + LEN_FRAC;
    localparam int NUMHI_W       = NUM_W - Q_W;
    localparam int DIV_STAGES    = Q_W;

    localparam logic signed [CTR_W-1:0] DRAW_CENTRE   = 15'sd5000;
    localparam logic [POS_W-1:0]        RADIUS_RESET  = POS_W'(64'd1 << FRACTION_BITS);
    localparam logic [POS_W-1:0]        POS_MAX       = {1'b0, {(POS_W-1){1'b1}}};

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_RADIUS = 2'd1,
        ST_ZERO_VEC   = 2'd2
    } status_t;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
        status_t          status;
    } result_t;

endpackage

>>> src/rps_sqrt_pipe.sv
// pipelined integer square root, one root bit per stage
module rps_sqrt_pipe (
    input  logic                        clk,
    input  logic                        en,
    input  logic [rps_pkg::SUM_W-1:0]   sum,
    output logic [rps_pkg::ROOT_W-1:0]  root
);
    import rps_pkg::*;

    logic [PAD_W-1:0]  sh_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0] r_reg   [SQRT_STAGES];
    logic [REM_W-1:0]  rem_reg [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [PAD_W-1:0]  sh_in;
        logic [ROOT_W-1:0] r_in;
        logic [REM_W-1:0]  rem_in;
        logic [REM_W+1:0]  cand;
        logic [REM_W+1:0]  trial;

        if (k == 0) begin : g_first
            assign sh_in  = PAD_W'(sum);
            assign r_in   = '0;
            assign rem_in = '0;
        end else begin : g_next
            assign sh_in  = sh_reg[k-1];
            assign r_in   = r_reg[k-1];
            assign rem_in = rem_reg[k-1];
        end

        // bring down the next pair of radicand bits, trial subtract 4r+1
        assign cand  = {rem_in, sh_in[PAD_W-1 -: 2]};
        assign trial = {1'b0, r_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sh_reg[k] <= {sh_in[PAD_W-3:0], 2'b00};
                if (cand >= trial)
                begin
                    rem_reg[k] <= REM_W'(cand - trial);
                    r_reg[k]   <= {r_in[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= REM_W'(cand);
                    r_reg[k]   <= {r_in[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign root = r_reg[SQRT_STAGES-1];

endmodule

>>> src/rps_div_lane.sv
// pipelined restoring divider, one quotient bit per stage, saturating
module rps_div_lane (
    input  logic                        clk,
    input  logic                        en,
    input  logic [rps_pkg::PROD_W-1:0]  prod,
    input  logic [rps_pkg::ROOT_W-1:0]  len,
    output logic [rps_pkg::POS_W-1:0]   q
);
    import rps_pkg::*;

    logic [NUM_W-1:0]   num;
    logic [NUMHI_W-1:0] num_hi;
    logic               sat0;

    logic [ROOT_W-1:0]  rem_reg [DIV_STAGES];
    logic [Q_W-1:0]     lo_reg  [DIV_STAGES];
    logic [Q_W-1:0]     q_reg   [DIV_STAGES];
    logic [ROOT_W-1:0]  len_reg [DIV_STAGES];
    logic               sat_reg [DIV_STAGES];

    assign num    = {prod, {LEN_FRAC{1'b0}}};
    assign num_hi = num[NUM_W-1 -: NUMHI_W];
    // quotient reaches 2^31 exactly when the upper part is not below the divisor
    assign sat0   = ROOT_W'(num_hi) >= len;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [ROOT_W-1:0] rem_in;
        logic [Q_W-1:0]    lo_in;
        logic [Q_W-1:0]    q_in;
        logic [ROOT_W-1:0] len_in;
        logic              sat_in;
        logic [ROOT_W:0]   cand;
        logic [ROOT_W:0]   dvs;

        if (k == 0) begin : g_first
            assign rem_in = ROOT_W'(num_hi);
            assign lo_in  = num[Q_W-1:0];
            assign q_in   = '0;
            assign len_in = len;
            assign sat_in = sat0;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign lo_in  = lo_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign len_in = len_reg[k-1];
            assign sat_in = sat_reg[k-1];
        end

        assign cand = {rem_in, lo_in[Q_W-1]};
        assign dvs  = {1'b0, len_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lo_reg[k]  <= {lo_in[Q_W-2:0], 1'b0};
                len_reg[k] <= len_in;
                sat_reg[k] <= sat_in;
                if (cand >= dvs)
                begin
                    rem_reg[k] <= ROOT_W'(cand - dvs);
                    q_reg[k]   <= {q_in[Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= ROOT_W'(cand);
                    q_reg[k]   <= {q_in[Q_W-2:0], 1'b0};
                end
            end
        end
    end

    assign q = sat_reg[DIV_STAGES-1] ? POS_MAX : {1'b0, q_reg[DIV_STAGES-1]};

endmodule

>>> src/random_point_on_sphere_scaler_core.sv
// top level: scales a centred random draw vector onto a sphere of set radius
//
// Input channel in_valid/in_ready carries draw_x, draw_y, draw_z (raw draws,
// centred inside as 5000 minus draw). Output channel out_valid/out_ready
// carries pos_x, pos_y, pos_z in signed Q16.16 and a status code
// (0 ok, 1 radius not positive, 2 zero-length vector; positions zero then).
// cfg_wr_en/cfg_wr_data write sphere_radius (Q16.16); write it
// only while no transaction is in flight.
// From input transaction to out_valid a result passes three front
// stages (centre, square, sum), 31 root stages, one multiply stage, 31
// divide stages and the output buffer.
// Throughput: one transaction per cycle while the output buffer is not full,
// set by the one-bit-per-stage root and divide pipelines.
// Reset clears the pipeline valid bits and the output buffer and sets the
// radius to 1.0. When the receiver stalls, a two-entry output buffer
// absorbs results; the pipeline and in_ready hold only once both entries
// are full, and nothing is dropped or repeated.
module random_point_on_sphere_scaler_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [rps_pkg::POS_W-1:0]         cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rps_pkg::DRAW_W-1:0]        draw_x,
    input  logic [rps_pkg::DRAW_W-1:0]        draw_y,
    input  logic [rps_pkg::DRAW_W-1:0]        draw_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [rps_pkg::POS_W-1:0]  pos_x,
    output logic signed [rps_pkg::POS_W-1:0]  pos_y,
    output logic signed [rps_pkg::POS_W-1:0]  pos_z,
    output logic [1:0]                        status
);
    import rps_pkg::*;

    typedef struct packed {
        logic signed [CTR_W-1:0] cx;
        logic signed [CTR_W-1:0] cy;
        logic signed [CTR_W-1:0] cz;
        logic                    zero;
    } side_t;

    typedef struct packed {
        logic    negx;
        logic    negy;
        logic    negz;
        status_t status;
    } tag_t;

    logic [POS_W-1:0] sphere_radius_reg;
    logic             en;

    // front stages
    logic                    v0_reg, v1_reg, v2_reg;
    logic signed [CTR_W-1:0] cx0_reg, cy0_reg, cz0_reg;
    logic signed [CTR_W-1:0] cx1_reg, cy1_reg, cz1_reg;
    logic [SQ_W-1:0]         sqx_reg, sqy_reg, sqz_reg;
    logic signed [2*CTR_W-1:0] px, py, pz;
    logic [SUM_W-1:0]        sum_reg;
    side_t                   side2_reg;

    // root stage delay line
    logic                    vs_reg   [SQRT_STAGES];
    side_t                   side_reg [SQRT_STAGES];
    logic [ROOT_W-1:0]       root;

    // multiply stage
    logic [CTR_W-1:0]        magx, magy, magz;
    status_t                 st_next;
    logic                    vm_reg;
    logic [PROD_W-1:0]       prodx_reg, prody_reg, prodz_reg;
    logic [ROOT_W-1:0]       len_reg;
    tag_t                    tagm_reg;

    // divide stage delay line
    logic                    vd_reg  [DIV_STAGES];
    tag_t                    tag_reg [DIV_STAGES];
    logic [POS_W-1:0]        qx, qy, qz;

    // output buffer
    result_t                 res;
    logic                    push, pop;
    logic [1:0]              cnt_reg, cnt_next;
    result_t                 buf0_reg, buf0_next, buf1_reg, buf1_next;

    assign en       = (cnt_reg != 2'd2);
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sphere_radius_reg <= RADIUS_RESET;
        else if (cfg_wr_en)
            sphere_radius_reg <= cfg_wr_data;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vm_reg <= 1'b0;
            for (int i = 0; i < SQRT_STAGES; i++)
                vs_reg[i] <= 1'b0;
            for (int i = 0; i < DIV_STAGES; i++)
                vd_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v0_reg    <= in_valid;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            vs_reg[0] <= v2_reg;
            for (int i = 1; i < SQRT_STAGES; i++)
                vs_reg[i] <= vs_reg[i-1];
            vm_reg    <= vs_reg[SQRT_STAGES-1];
            vd_reg[0] <= vm_reg;
            for (int i = 1; i < DIV_STAGES; i++)
                vd_reg[i] <= vd_reg[i-1];
        end
    end

    assign px = cx0_reg * cx0_reg;
    assign py = cy0_reg * cy0_reg;
    assign pz = cz0_reg * cz0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx0_reg <= DRAW_CENTRE - $signed({1'b0, draw_x});
            cy0_reg <= DRAW_CENTRE - $signed({1'b0, draw_y});
            cz0_reg <= DRAW_CENTRE - $signed({1'b0, draw_z});

            sqx_reg <= SQ_W'(px);
            sqy_reg <= SQ_W'(py);
            sqz_reg <= SQ_W'(pz);
            cx1_reg <= cx0_reg;
            cy1_reg <= cy0_reg;
            cz1_reg <= cz0_reg;

            sum_reg        <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
            side2_reg.cx   <= cx1_reg;
            side2_reg.cy   <= cy1_reg;
            side2_reg.cz   <= cz1_reg;
            side2_reg.zero <= (cx1_reg == '0) && (cy1_reg == '0) && (cz1_reg == '0);

            side_reg[0] <= side2_reg;
            for (int i = 1; i < SQRT_STAGES; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    rps_sqrt_pipe u_sqrt (
        .clk  (clk),
        .en   (en),
        .sum  (sum_reg),
        .root (root)
    );

    always_comb
    begin
        magx = side_reg[SQRT_STAGES-1].cx[CTR_W-1] ? CTR_W'(-side_reg[SQRT_STAGES-1].cx)
                                                   : CTR_W'(side_reg[SQRT_STAGES-1].cx);
        magy = side_reg[SQRT_STAGES-1].cy[CTR_W-1] ? CTR_W'(-side_reg[SQRT_STAGES-1].cy)
                                                   : CTR_W'(side_reg[SQRT_STAGES-1].cy);
        magz = side_reg[SQRT_STAGES-1].cz[CTR_W-1] ? CTR_W'(-side_reg[SQRT_STAGES-1].cz)
                                                   : CTR_W'(side_reg[SQRT_STAGES-1].cz);
        // radius check wins over the zero vector
        if (sphere_radius_reg[POS_W-1] || (sphere_radius_reg == '0))
            st_next = ST_BAD_RADIUS;
        else if (side_reg[SQRT_STAGES-1].zero)
            st_next = ST_ZERO_VEC;
        else
            st_next = ST_OK;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prodx_reg <= PROD_W'(MAG_W'(magx)) * PROD_W'(sphere_radius_reg[RAD_W-1:0]);
            prody_reg <= PROD_W'(MAG_W'(magy)) * PROD_W'(sphere_radius_reg[RAD_W-1:0]);
            prodz_reg <= PROD_W'(MAG_W'(magz)) * PROD_W'(sphere_radius_reg[RAD_W-1:0]);
            len_reg   <= root;
            tagm_reg.negx   <= side_reg[SQRT_STAGES-1].cx[CTR_W-1];
            tagm_reg.negy   <= side_reg[SQRT_STAGES-1].cy[CTR_W-1];
            tagm_reg.negz   <= side_reg[SQRT_STAGES-1].cz[CTR_W-1];
            tagm_reg.status <= st_next;

            tag_reg[0] <= tagm_reg;
            for (int i = 1; i < DIV_STAGES; i++)
                tag_reg[i] <= tag_reg[i-1];
        end
    end

    rps_div_lane u_div_x (.clk(clk), .en(en), .prod(prodx_reg), .len(len_reg), .q(qx));
    rps_div_lane u_div_y (.clk(clk), .en(en), .prod(prody_reg), .len(len_reg), .q(qy));
    rps_div_lane u_div_z (.clk(clk), .en(en), .prod(prodz_reg), .len(len_reg), .q(qz));

    always_comb
    begin
        res.status = tag_reg[DIV_STAGES-1].status;
        if (tag_reg[DIV_STAGES-1].status != ST_OK)
        begin
            res.pos_x = '0;
            res.pos_y = '0;
            res.pos_z = '0;
        end
        else
        begin
            res.pos_x = tag_reg[DIV_STAGES-1].negx ? POS_W'(-qx) : qx;
            res.pos_y = tag_reg[DIV_STAGES-1].negy ? POS_W'(-qy) : qy;
            res.pos_z = tag_reg[DIV_STAGES-1].negz ? POS_W'(-qz) : qz;
        end
    end

    assign push = en && vd_reg[DIV_STAGES-1];
    assign pop  = (cnt_reg != 2'd0) && out_ready;

    always_comb
    begin
        cnt_next  = cnt_reg;
        buf0_next = buf0_reg;
        buf1_next = buf1_reg;
        if (push && pop)
        begin
            if (cnt_reg == 2'd1)
                buf0_next = res;
            else
            begin
                buf0_next = buf1_reg;
                buf1_next = res;
            end
        end
        else if (pop)
        begin
            buf0_next = buf1_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
                buf0_next = res;
            else
                buf1_next = res;
            cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        buf0_reg <= buf0_next;
        buf1_reg <= buf1_next;
    end

    assign out_valid = (cnt_reg != 2'd0);
    assign pos_x     = buf0_reg.pos_x;
    assign pos_y     = buf0_reg.pos_y;
    assign pos_z     = buf0_reg.pos_z;
    assign status    = buf0_reg.status;

endmodule

>>> src/rps_checker.sv
// port-level checks for the sphere point scaler, bound to the top level
module rps_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [rps_pkg::POS_W-1:0]  pos_x,
    input logic signed [rps_pkg::POS_W-1:0]  pos_y,
    input logic signed [rps_pkg::POS_W-1:0]  pos_z,
    input logic [1:0]                        status
);
    import rps_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pos_x) && $stable(pos_y) && $stable(pos_z)
                                    && $stable(status))
        else $error("output transaction changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (pos_x == '0) && (pos_y == '0) && (pos_z == '0))
        else $error("nonzero position with error status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK) || (status == ST_BAD_RADIUS) || (status == ST_ZERO_VEC))
        else $error("unknown status code");

endmodule

bind random_point_on_sphere_scaler_core rps_checker u_rps_checker (.*);

>>> tb/tb_random_point_on_sphere_scaler_core.sv
// testbench for the sphere point scaler: directed and random draws checked against a predictor
module tb_random_point_on_sphere_scaler_core;
    import rps_pkg::*;

    typedef struct {
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic [POS_W-1:0] pz;
        status_t          st;
    } point_t;

    localparam int CYCLE_LIMIT = 600000;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [POS_W-1:0]    cfg_wr_data;
    logic                in_valid;
    logic                in_ready;
    logic [DRAW_W-1:0]   draw_x;
    logic [DRAW_W-1:0]   draw_y;
    logic [DRAW_W-1:0]   draw_z;
    logic                out_valid;
    logic                out_ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [1:0]          status;

    point_t          pending_points[$];
    logic [POS_W-1:0] radius_now;
    int              tx_idle_pct;
    int              rx_stall_pct;
    bit              rx_hold;
    int              errors;
    int              cycles;

    random_point_on_sphere_scaler_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .draw_x(draw_x), .draw_y(draw_y), .draw_z(draw_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [63:0] int_root(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [POS_W-1:0] scale_axis(int c, logic [63:0] rad, logic [63:0] len);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (c < 0) ? 64'(-c) : 64'(c);
        q = ((mag * rad) << LEN_FRAC) / len;
        if (q > 64'(POS_MAX))
            q = 64'(POS_MAX);
        if (c < 0)
            return 32'(0) - q[31:0];
        return q[31:0];
    endfunction

    function automatic point_t sphere_point(logic [DRAW_W-1:0] dx, logic [DRAW_W-1:0] dy,
                                            logic [DRAW_W-1:0] dz, logic [POS_W-1:0] rad);
        point_t p;
        int cx;
        int cy;
        int cz;
        logic [63:0] sq;
        logic [63:0] len;
        p.px = 0;
        p.py = 0;
        p.pz = 0;
        if (rad == 0 || rad[POS_W-1])
        begin
            p.st = ST_BAD_RADIUS;
            return p;
        end
        cx = 5000 - int'(dx);
        cy = 5000 - int'(dy);
        cz = 5000 - int'(dz);
        sq = 64'(cx * cx) + 64'(cy * cy) + 64'(cz * cz);
        if (sq == 0)
        begin
            p.st = ST_ZERO_VEC;
            return p;
        end
        len = int_root(sq << (2 * LEN_FRAC));
        p.px = scale_axis(cx, 64'(rad), len);
        p.py = scale_axis(cy, 64'(rad), len);
        p.pz = scale_axis(cz, 64'(rad), len);
        p.st = ST_OK;
        return p;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // result checker and receiver pacing
    always @(posedge clk)
    begin
        point_t w;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_points.size() == 0)
                    report("unexpected transaction", {pos_x, pos_y}, 0);
                else
                begin
                    w = pending_points.pop_front();
                    if (pos_x !== w.px)
                        report("pos_x", pos_x, w.px);
                    if (pos_y !== w.py)
                        report("pos_y", pos_y, w.py);
                    if (pos_z !== w.pz)
                        report("pos_z", pos_z, w.pz);
                    if (status !== w.st)
                        report("status", status, w.st);
                end
            end
            out_ready <= rx_hold ? 1'b0 : ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // called just after a rising edge; returns just after the accepting edge
    task automatic send_draw(logic [DRAW_W-1:0] dx, logic [DRAW_W-1:0] dy,
                             logic [DRAW_W-1:0] dz);
        int gap;
        gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        draw_x <= dx;
        draw_y <= dy;
        draw_z <= dz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_points.push_back(sphere_point(dx, dy, dz, radius_now));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_radius(logic [POS_W-1:0] r);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= r;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        radius_now = r;
    endtask

    function automatic logic [DRAW_W-1:0] rand_draw();
        // mostly nominal range, sometimes the full field
        if ($urandom_range(9) == 0)
            return DRAW_W'($urandom_range(16383));
        return DRAW_W'($urandom_range(9999));
    endfunction

    function automatic logic [POS_W-1:0] rand_radius();
        case ($urandom_range(9))
            0: return POS_MAX;
            1: return 32'h8000_0000 | $urandom;
            2: return 32'(1);
            default: return {1'b0, 31'($urandom)};
        endcase
    endfunction

    task automatic test_extremes();
        send_draw(0, 0, 0);
        send_draw(9999, 9999, 9999);
        send_draw(5000, 5000, 5000);
        send_draw(16383, 16383, 16383);
        send_draw(0, 5000, 5000);
        send_draw(5000, 16383, 5000);
        send_draw(5000, 5000, 9999);
        send_draw(4999, 5000, 5000);
        send_draw(0, 9999, 16383);
        drain();
    endtask

    task automatic test_radius_cases();
        set_radius(0);
        send_draw(1234, 777, 9000);
        send_draw(5000, 5000, 5000);
        drain();
        set_radius(32'hFFFF_FFFF);
        send_draw(5000, 5000, 5000);
        send_draw(100, 200, 300);
        drain();
        set_radius(32'h8000_0000);
        send_draw(9999, 0, 4000);
        drain();
        // largest positive radius, with axis-aligned and general draws
        set_radius(POS_MAX);
        send_draw(0, 5000, 5000);
        send_draw(16383, 5000, 5000);
        send_draw(1, 2, 3);
        drain();
        set_radius(32'(1));
        send_draw(4999, 5001, 5000);
        send_draw(0, 0, 0);
        drain();
        set_radius(RADIUS_RESET);
    endtask

    task automatic test_random(int n, int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        for (int i = 0; i < n; i++)
        begin
            if (i % 100 == 0 && i != 0)
            begin
                drain();
                set_radius(rand_radius());
            end
            if ($urandom_range(49) == 0)
                send_draw(5000, 5000, 5000);
            else
                send_draw(rand_draw(), rand_draw(), rand_draw());
        end
        drain();
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        set_radius({1'b0, 31'($urandom)});
        fork
            begin
                rx_hold = 1'b1;
                repeat (300) @(posedge clk);
                rx_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 120; i++)
                    send_draw(rand_draw(), rand_draw(), rand_draw());
            end
        join
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        draw_x = '0;
        draw_y = '0;
        draw_z = '0;
        out_ready = 1'b0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold = 1'b0;
        errors = 0;
        cycles = 0;
        radius_now = RADIUS_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_radius_cases();
        test_random(400, 0, 0);
        test_random(400, 50, 0);
        test_random(400, 0, 50);
        test_random(400, 19, 19);
        test_backpressure();
        repeat (80) @(posedge clk);
        if (errors == 0 && pending_points.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
